// File: hw/rtl/stuffed_frame_encoder_assert.svh
// assertion macros shared by the frame encoder rtl
`ifndef STUFFED_FRAME_ENCODER_ASSERT_SVH
`define STUFFED_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication
`define SFE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sfe_pkg.sv
// shared types and constants of the stuffed frame encoder
package sfe_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 5;

  localparam logic [2:0] REG_FLAG      = 3'd0;
  localparam logic [2:0] REG_ESCAPE    = 3'd1;
  localparam logic [2:0] REG_ADDRESS   = 3'd2;
  localparam logic [2:0] REG_CTRL_EVEN = 3'd3;
  localparam logic [2:0] REG_CTRL_ODD  = 3'd4;
  localparam logic [2:0] REG_MASK      = 3'd5;
  localparam logic [2:0] REG_CHK_EN    = 3'd6;

  typedef struct packed {
    logic [BYTE_W-1:0] flag;
    logic [BYTE_W-1:0] escape;
    logic [BYTE_W-1:0] address;
    logic [BYTE_W-1:0] ctrl_even;
    logic [BYTE_W-1:0] ctrl_odd;
    logic [BYTE_W-1:0] mask;
    logic              check_en;
  } sfe_cfg_t;

  typedef struct packed {
    logic              header;
    logic [BYTE_W-1:0] control;
    logic [BYTE_W-1:0] data;
    logic              data_stuff;
    logic              last;
    logic [BYTE_W-1:0] check;
    logic              check_stuff;
  } sfe_desc_t;

  typedef enum logic [3:0] {
    ST_START,
    ST_FLAG,
    ST_ADDR,
    ST_CTRL,
    ST_HCHK,
    ST_DESC,
    ST_DATA,
    ST_CESC,
    ST_CHK,
    ST_CLOSE
  } sfe_step_t;

endpackage

// File: hw/rtl/stuffed_frame_encoder.sv
// top level of the stuffed frame encoder with its register file
// an accepted item is stored in the queue; its line beats come from the output register
// throughput: one line beat per cycle unless stalled or queue empty; an item takes 1 to 9
// beats (header 4 on first beat, payload 1 or 2, check 1 or 2, closing flag 1 on last beat)
// the front end takes a new beat each cycle until the descriptor queue is full
// reset: synchronous active low, clears frame state, queue and registers to defaults
module stuffed_frame_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfe_pkg::ADDR_W-1:0] paddr,
  input  logic [sfe_pkg::DATA_W-1:0] pwdata,
  output logic [sfe_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sfe_pkg::BYTE_W-1:0] in_payload_byte,
  input  logic                       in_packet_end,
  input  logic                       in_sequence_bit,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sfe_pkg::BYTE_W-1:0] out_line_byte,
  output logic                       out_frame_end,
  output logic                       out_run_end
);
  import sfe_pkg::*;

  sfe_cfg_t   cfg_r, cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;
  logic       push, pop, q_full, q_empty;
  sfe_desc_t  desc_in, desc_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_FLAG:      cfg_nxt.flag      = pwdata[BYTE_W-1:0];
        REG_ESCAPE:    cfg_nxt.escape    = pwdata[BYTE_W-1:0];
        REG_ADDRESS:   cfg_nxt.address   = pwdata[BYTE_W-1:0];
        REG_CTRL_EVEN: cfg_nxt.ctrl_even = pwdata[BYTE_W-1:0];
        REG_CTRL_ODD:  cfg_nxt.ctrl_odd  = pwdata[BYTE_W-1:0];
        REG_MASK:      cfg_nxt.mask      = pwdata[BYTE_W-1:0];
        REG_CHK_EN:    cfg_nxt.check_en  = pwdata[0];
        default:       cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_FLAG:      prdata = DATA_W'(cfg_r.flag);
      REG_ESCAPE:    prdata = DATA_W'(cfg_r.escape);
      REG_ADDRESS:   prdata = DATA_W'(cfg_r.address);
      REG_CTRL_EVEN: prdata = DATA_W'(cfg_r.ctrl_even);
      REG_CTRL_ODD:  prdata = DATA_W'(cfg_r.ctrl_odd);
      REG_MASK:      prdata = DATA_W'(cfg_r.mask);
      REG_CHK_EN:    prdata = DATA_W'(cfg_r.check_en);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag      <= 8'h7E;
      cfg_r.escape    <= 8'h7D;
      cfg_r.address   <= 8'h03;
      cfg_r.ctrl_even <= 8'h00;
      cfg_r.ctrl_odd  <= 8'h40;
      cfg_r.mask      <= 8'h00;
      cfg_r.check_en  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sfe_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_i           (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_payload_byte (in_payload_byte),
    .in_packet_end   (in_packet_end),
    .in_sequence_bit (in_sequence_bit),
    .q_full_i        (q_full),
    .push_o          (push),
    .desc_o          (desc_in)
  );

  sfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .din_i   (desc_in),
    .pop_i   (pop),
    .dout_o  (desc_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  sfe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_i         (cfg_r),
    .head_i        (desc_head),
    .head_valid_i  (!q_empty),
    .pop_o         (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_line_byte (out_line_byte),
    .out_frame_end (out_frame_end),
    .out_run_end   (out_run_end)
  );

endmodule

// File: hw/rtl/sfe_front.sv
// front end: accepts payload beats, tracks frame state and builds descriptors
`include "stuffed_frame_encoder_assert.svh"

module sfe_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sfe_pkg::sfe_cfg_t         cfg_i,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [sfe_pkg::BYTE_W-1:0] in_payload_byte,
  input  logic                      in_packet_end,
  input  logic                      in_sequence_bit,
  input  logic                      q_full_i,
  output logic                      push_o,
  output sfe_pkg::sfe_desc_t        desc_o
);
  import sfe_pkg::*;

  logic              inside_frame_r, inside_frame_nxt;
  logic [BYTE_W-1:0] running_check_r, running_check_nxt;
  logic [BYTE_W-1:0] check_v;

  assign in_stall = q_full_i;
  assign push_o   = in_valid && !q_full_i;
  assign check_v  = inside_frame_r ? (running_check_r ^ in_payload_byte) : in_payload_byte;

  always_comb begin
    desc_o.header      = !inside_frame_r;
    desc_o.control     = in_sequence_bit ? cfg_i.ctrl_odd : cfg_i.ctrl_even;
    desc_o.data        = in_payload_byte;
    desc_o.data_stuff  = (in_payload_byte == cfg_i.flag) || (in_payload_byte == cfg_i.escape);
    desc_o.last        = in_packet_end;
    desc_o.check       = check_v;
    desc_o.check_stuff = cfg_i.check_en && ((check_v == cfg_i.flag) || (check_v == cfg_i.escape));
  end

  always_comb begin
    inside_frame_nxt  = inside_frame_r;
    running_check_nxt = running_check_r;
    if (push_o) begin
      inside_frame_nxt  = !in_packet_end;
      running_check_nxt = in_packet_end ? '0 : check_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_frame_r  <= 1'b0;
      running_check_r <= '0;
    end else begin
      inside_frame_r  <= inside_frame_nxt;
      running_check_r <= running_check_nxt;
    end
  end

  `SFE_ASSERT_NXT(a_end_closes_frame, clk, rst_n, push_o && in_packet_end, !inside_frame_r, "frame left open after last beat")
  `SFE_ASSERT_IMP(a_idle_check_clear, clk, rst_n, !inside_frame_r, running_check_r == '0, "running check not cleared between frames")

endmodule

// File: hw/rtl/sfe_queue.sv
// descriptor queue between front and back end
`include "stuffed_frame_encoder_assert.svh"

module sfe_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  sfe_pkg::sfe_desc_t din_i,
  input  logic               pop_i,
  output sfe_pkg::sfe_desc_t dout_o,
  output logic               full_o,
  output logic               empty_o
);
  import sfe_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sfe_desc_t        entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign empty_o = (count_r == '0);
  assign dout_o  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      entries_r[wr_ptr_r] <= din_i;
    end
  end

  `SFE_ASSERT_IMP(a_no_overfill, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH), "queue count above depth")
  `SFE_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop_i, !empty_o, "pop from empty queue")

endmodule

// File: hw/rtl/sfe_back.sv
// back end: sequences header, stuffed payload, check and closing flag onto the line
`include "stuffed_frame_encoder_assert.svh"

module sfe_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sfe_pkg::sfe_cfg_t          cfg_i,
  input  sfe_pkg::sfe_desc_t         head_i,
  input  logic                       head_valid_i,
  output logic                       pop_o,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sfe_pkg::BYTE_W-1:0] out_line_byte,
  output logic                       out_frame_end,
  output logic                       out_run_end
);
  import sfe_pkg::*;

  sfe_step_t         step_r, step_nxt;
  sfe_step_t         cur_step, after_step;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_fend_r, out_rend_r;
  logic [BYTE_W-1:0] byte_v;
  logic              fend_v, done_v, load;

  assign load  = head_valid_i && (!out_valid_r || !out_stall);
  assign pop_o = load && done_v;

  always_comb begin
    cur_step = step_r;
    if (step_r == ST_START) begin
      cur_step = head_i.header ? ST_FLAG : (head_i.data_stuff ? ST_DESC : ST_DATA);
    end
    byte_v     = '0;
    fend_v     = 1'b0;
    done_v     = 1'b0;
    after_step = ST_START;
    unique case (cur_step)
      ST_FLAG: begin
        byte_v     = cfg_i.flag;
        after_step = ST_ADDR;
      end
      ST_ADDR: begin
        byte_v     = cfg_i.address;
        after_step = ST_CTRL;
      end
      ST_CTRL: begin
        byte_v     = head_i.control;
        after_step = ST_HCHK;
      end
      ST_HCHK: begin
        byte_v     = cfg_i.address ^ head_i.control;
        after_step = head_i.data_stuff ? ST_DESC : ST_DATA;
      end
      ST_DESC: begin
        byte_v     = cfg_i.escape;
        after_step = ST_DATA;
      end
      ST_DATA: begin
        byte_v = head_i.data_stuff ? (head_i.data ^ cfg_i.mask) : head_i.data;
        if (head_i.last) begin
          after_step = head_i.check_stuff ? ST_CESC : ST_CHK;
        end else begin
          done_v = 1'b1;
        end
      end
      ST_CESC: begin
        byte_v     = cfg_i.escape;
        after_step = ST_CHK;
      end
      ST_CHK: begin
        byte_v     = head_i.check_stuff ? (head_i.check ^ cfg_i.mask) : head_i.check;
        after_step = ST_CLOSE;
      end
      ST_CLOSE: begin
        byte_v = cfg_i.flag;
        fend_v = 1'b1;
        done_v = 1'b1;
      end
      default: begin
        byte_v = '0;
      end
    endcase

    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      step_nxt      = done_v ? ST_START : after_step;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_START;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= byte_v;
      out_fend_r <= fend_v;
      out_rend_r <= done_v;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_line_byte = out_byte_r;
  assign out_frame_end = out_fend_r;
  assign out_run_end   = out_rend_r;

  `SFE_ASSERT_IMP(a_close_ends_run, clk, rst_n, out_valid_r && out_fend_r, out_rend_r, "closing flag not marked as run end")

endmodule

// File: tb/tb.sv
// self-checking testbench for the stuffed frame encoder
`timescale 1ns / 100ps

module tb;
  import sfe_pkg::*;

  localparam logic [2:0] REG_NONE = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [BYTE_W-1:0] line_byte;
    logic              frame_end;
    logic              run_end;
  } line_beat_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   in_payload_byte = '0;
  logic                in_packet_end = 1'b0;
  logic                in_sequence_bit = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BYTE_W-1:0]   out_line_byte;
  logic                out_frame_end;
  logic                out_run_end;

  sfe_cfg_t            line_cfg;
  logic                frame_open;
  logic [BYTE_W-1:0]   frame_check;
  line_beat_t          expected_line[$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned payload_beats = 0;
  int unsigned frames_sent = 0;
  int unsigned line_beats = 0;
  int unsigned reg_writes = 0;

  stuffed_frame_encoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_payload_byte (in_payload_byte),
    .in_packet_end   (in_packet_end),
    .in_sequence_bit (in_sequence_bit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_line_byte   (out_line_byte),
    .out_frame_end   (out_frame_end),
    .out_run_end     (out_run_end)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("stuffed_frame_encoder regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    line_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      line_beats++;
      if (expected_line.size() == 0) begin
        $display("%0t: unexpected line beat byte=%02h frame_end=%0b run_end=%0b",
                 $time, out_line_byte, out_frame_end, out_run_end);
        mismatches++;
      end else begin
        want = expected_line.pop_front();
        if (out_line_byte !== want.line_byte) begin
          $display("%0t: line_byte expected %02h actual %02h",
                   $time, want.line_byte, out_line_byte);
          mismatches++;
        end
        if (out_frame_end !== want.frame_end) begin
          $display("%0t: frame_end expected %0b actual %0b",
                   $time, want.frame_end, out_frame_end);
          mismatches++;
        end
        if (out_run_end !== want.run_end) begin
          $display("%0t: run_end expected %0b actual %0b",
                   $time, want.run_end, out_run_end);
          mismatches++;
        end
      end
    end
  end

  function automatic void push_line(input logic [BYTE_W-1:0] v, input logic closing);
    line_beat_t b;
    b.line_byte = v;
    b.frame_end = closing;
    b.run_end = 1'b0;
    expected_line.push_back(b);
  endfunction

  function automatic void push_stuffed(input logic [BYTE_W-1:0] v);
    if (v == line_cfg.flag || v == line_cfg.escape) begin
      push_line(line_cfg.escape, 1'b0);
      push_line(v ^ line_cfg.mask, 1'b0);
    end else begin
      push_line(v, 1'b0);
    end
  endfunction

  function automatic void encode_payload(input logic [BYTE_W-1:0] b, input logic last,
                                         input logic seq);
    logic [BYTE_W-1:0] ctl;
    if (!frame_open) begin
      ctl = seq ? line_cfg.ctrl_odd : line_cfg.ctrl_even;
      push_line(line_cfg.flag, 1'b0);
      push_line(line_cfg.address, 1'b0);
      push_line(ctl, 1'b0);
      push_line(line_cfg.address ^ ctl, 1'b0);
      frame_check = '0;
      frame_open = 1'b1;
    end
    frame_check = frame_check ^ b;
    push_stuffed(b);
    if (last) begin
      if (line_cfg.check_en) begin
        push_stuffed(frame_check);
      end else begin
        push_line(frame_check, 1'b0);
      end
      push_line(line_cfg.flag, 1'b1);
      frame_open = 1'b0;
      frame_check = '0;
    end
    expected_line[expected_line.size()-1].run_end = 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] register_value(input logic [2:0] idx);
    case (idx)
      REG_FLAG:      return DATA_W'(line_cfg.flag);
      REG_ESCAPE:    return DATA_W'(line_cfg.escape);
      REG_ADDRESS:   return DATA_W'(line_cfg.address);
      REG_CTRL_EVEN: return DATA_W'(line_cfg.ctrl_even);
      REG_CTRL_ODD:  return DATA_W'(line_cfg.ctrl_odd);
      REG_MASK:      return DATA_W'(line_cfg.mask);
      REG_CHK_EN:    return DATA_W'(line_cfg.check_en);
      default:       return '0;
    endcase
  endfunction

  task automatic write_register(input logic [2:0] idx, input logic [DATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FLAG:      line_cfg.flag = v[7:0];
      REG_ESCAPE:    line_cfg.escape = v[7:0];
      REG_ADDRESS:   line_cfg.address = v[7:0];
      REG_CTRL_EVEN: line_cfg.ctrl_even = v[7:0];
      REG_CTRL_ODD:  line_cfg.ctrl_odd = v[7:0];
      REG_MASK:      line_cfg.mask = v[7:0];
      REG_CHK_EN:    line_cfg.check_en = v[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic read_register(input logic [2:0] idx);
    logic [DATA_W-1:0] want;
    want = register_value(idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: register %0d read expected %08h actual %08h", $time, idx, want, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_line_config(input logic [7:0] flag, input logic [7:0] esc,
                                 input logic [7:0] addr, input logic [7:0] ce,
                                 input logic [7:0] co, input logic [7:0] mask,
                                 input logic chk);
    write_register(REG_FLAG, {24'($urandom), flag});
    write_register(REG_ESCAPE, {24'($urandom), esc});
    write_register(REG_ADDRESS, {24'($urandom), addr});
    write_register(REG_CTRL_EVEN, {24'($urandom), ce});
    write_register(REG_CTRL_ODD, {24'($urandom), co});
    write_register(REG_MASK, {24'($urandom), mask});
    write_register(REG_CHK_EN, {31'($urandom), chk});
  endtask

  task automatic send_beat(input logic [7:0] b, input logic last, input logic seq);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    encode_payload(b, last, seq);
    in_valid <= 1'b1;
    in_payload_byte <= b;
    in_packet_end <= last;
    in_sequence_bit <= seq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    payload_beats++;
    if (last) frames_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_line.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0:       return line_cfg.flag;
      1:       return line_cfg.escape;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_packet(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_beat(pick_byte(), i == len - 1, 1'($urandom));
    end
  endtask

  task automatic test_register_access();
    for (int i = 0; i < 7; i++) read_register(3'(i));
    set_line_config(8'hA5, 8'h5A, 8'h81, 8'h18, 8'hE7, 8'h3C, 1'b1);
    for (int i = 0; i < 7; i++) read_register(3'(i));
    write_register(REG_NONE, 32'hFFFF_FFFF);
    for (int i = 0; i < 7; i++) read_register(3'(i));
    set_line_config(8'h7E, 8'h7D, 8'h03, 8'h00, 8'h40, 8'h00, 1'b0);
  endtask

  task automatic test_default_framing();
    send_beat(8'h7E, 1'b1, 1'b0);
    send_beat(8'h7D, 1'b0, 1'b1);
    wait_drain();
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    wait_drain();
  endtask

  task automatic test_check_stuffing();
    write_register(REG_CHK_EN, 32'h1);
    send_beat(8'h7E, 1'b0, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'h7D, 1'b1, 1'b0);
    wait_drain();
    write_register(REG_ESCAPE, 32'h7E);
    write_register(REG_MASK, 32'h20);
    send_beat(8'h7E, 1'b1, 1'b0);
    send_beat(8'h7D, 1'b1, 1'b1);
    wait_drain();
  endtask

  task automatic test_extreme_config();
    set_line_config(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b1);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);
    send_beat(8'h80, 1'b0, 1'b1);
    send_beat(8'h01, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_line_config(8'h7E, 8'h7D, 8'h03, 8'h00, 8'h40, 8'h00, 1'b0);
        1: set_line_config(8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        2: set_line_config(8'h55, 8'h55, 8'($urandom), 8'($urandom), 8'($urandom),
                           8'h20, 1'b1);
        default: set_line_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom), 1'($urandom));
      endcase
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      start = payload_beats;
      while (payload_beats - start < 80) begin
        if ($urandom_range(9) == 0) send_packet($urandom_range(20, 9));
        else send_packet($urandom_range(8, 1));
      end
      wait_drain();
      idle_pct = 0;
      stall_pct = 0;
    end
  endtask

  initial begin
    line_cfg = '{flag: 8'h7E, escape: 8'h7D, address: 8'h03, ctrl_even: 8'h00,
                 ctrl_odd: 8'h40, mask: 8'h00, check_en: 1'b0};
    frame_open = 1'b0;
    frame_check = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_default_framing();
    test_check_stuffing();
    test_extreme_config();
    test_random_traffic();
    wait_drain();
    repeat (20) @(posedge clk);
    $display("covered %0d payload beats in %0d frames, %0d line beats checked",
             payload_beats, frames_sent, line_beats);
    $display("register writes: %0d, across reset, extreme and random line settings",
             reg_writes);
    if (mismatches == 0) begin
      $display("stuffed_frame_encoder regression: pass");
    end else begin
      $display("stuffed_frame_encoder regression: fail");
    end
    $finish;
  end

endmodule
